// ----- sv/hse_pkg.sv -----
// Shared types, constants and compare function for the heap sort engine.
`default_nettype none

package hse_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int DATA_W    = 32;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int CHILD_W   = ADDR_W + 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BUILD_RD,
      ST_SIFT_START,
      ST_SIFT,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic                     en;
      logic [ADDR_W-1:0]        addr;
      logic signed [DATA_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr_a;
      logic [ADDR_W-1:0] addr_b;
   } mem_rd_type;

   function automatic logic outranks(input logic signed [DATA_W-1:0] a,
                                     input logic signed [DATA_W-1:0] b,
                                     input logic                     min_heap);
      return min_heap ? (a < b) : (a > b);
   endfunction

endpackage

`default_nettype wire

// ----- sv/hse_ram.sv -----
// Element store: one write port, two read ports with registered read data.
`default_nettype none

module hse_ram import hse_pkg::*; (
   input  wire logic                     clock,
   input  wire mem_wr_type               wr,
   input  wire mem_rd_type               rd,
   output logic signed [DATA_W-1:0]      rd_a_data,
   output logic signed [DATA_W-1:0]      rd_b_data
);

   logic signed [DATA_W-1:0] mem_ff [MAX_ITEMS];
   logic signed [DATA_W-1:0] rd_a_ff;
   logic signed [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_ff <= mem_ff[rd.addr_a];
      rd_b_ff <= mem_ff[rd.addr_b];
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

`default_nettype wire

// ----- sv/heap_sort_engine_unit.sv -----
// Heap sort engine top level: load sequencer, in-place heap sort and result streaming.
// Loading takes each transaction while busy is low; busy stays low while a set is collected.
// The transaction flagged last starts the sort: a read and a sift start per heap node built,
// a swap read and a swap write per root swap, then sift steps as the value sinks, all on the
// element store. Results stream one per cycle, n in all; busy drops in the cycle of the final
// result. Synchronous active-high reset; store stays undefined.
`default_nettype none

module heap_sort_engine_unit import hse_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [DATA_W-1:0] req_item_value,
   input  wire logic                     req_item_last,
   output logic                          rsp_valid,
   output logic signed [DATA_W-1:0]      rsp_sorted_value,
   output logic                          rsp_result_last,
   output logic                          rsp_overflowed,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic                     csr_sort_descending
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     ovf_ff, ovf_in;
   logic                     mode_ff;
   logic                     min_heap_ff, min_heap_in;
   logic                     ovf_run_ff, ovf_run_in;
   logic [CNT_W-1:0]         n_ff, n_in;
   logic [CNT_W-1:0]         len_ff, len_in;
   logic [CNT_W-1:0]         ks_ff, ks_in;
   logic [ADDR_W-1:0]        node_ff, node_in;
   logic [ADDR_W-1:0]        bnode_ff, bnode_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic                     build_ff, build_in;
   logic signed [DATA_W-1:0] hold_ff, hold_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_last_ff, rsp_last_in;

   mem_wr_type               wr;
   mem_rd_type               rd;
   logic signed [DATA_W-1:0] rd_a_data;
   logic signed [DATA_W-1:0] rd_b_data;

   logic                     accept;
   logic                     full;
   logic [CNT_W-1:0]         n_new;
   logic [CNT_W-1:0]         half_m1;
   logic [CNT_W-1:0]         ks_m1;
   logic [CHILD_W-1:0]       l_idx;
   logic [CHILD_W-1:0]       r_idx;
   logic                     l_ok;
   logic                     r_ok;
   logic                     pick_l;
   logic                     pick_r;
   logic                     sift_done;
   logic signed [DATA_W-1:0] best_val;
   logic [ADDR_W-1:0]        best_node;
   logic [ADDR_W-1:0]        best_l_addr;
   logic [ADDR_W-1:0]        node_l_addr;
   logic                     out_last;

   hse_ram u_ram (
      .clock     (clock),
      .wr        (wr),
      .rd        (rd),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign n_new     = full ? count_ff : count_ff + CNT_W'(1);
   assign half_m1   = (n_new >> 1) - CNT_W'(1);
   assign ks_m1     = ks_ff - CNT_W'(1);
   assign out_last  = ({1'b0, idx_ff} == n_ff - CNT_W'(1));

   // compare the held value against both children of the current node
   always_comb begin
      l_idx       = {1'b0, node_ff, 1'b1};
      r_idx       = l_idx + CHILD_W'(1);
      l_ok        = (l_idx < {1'b0, len_ff});
      r_ok        = (r_idx < {1'b0, len_ff});
      pick_l      = 1'b0;
      pick_r      = 1'b0;
      best_val    = hold_ff;
      if (l_ok && outranks(rd_a_data, hold_ff, min_heap_ff)) begin
         pick_l   = 1'b1;
         best_val = rd_a_data;
      end
      if (r_ok && outranks(rd_b_data, best_val, min_heap_ff)) begin
         pick_l   = 1'b0;
         pick_r   = 1'b1;
         best_val = rd_b_data;
      end
      sift_done   = !pick_l && !pick_r;
      best_node   = pick_r ? r_idx[ADDR_W-1:0] : l_idx[ADDR_W-1:0];
      best_l_addr = ADDR_W'({best_node, 1'b1});
      node_l_addr = ADDR_W'({node_ff, 1'b1});
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_item_last) begin
               state_in = (n_new > CNT_W'(1)) ? ST_BUILD_RD : ST_OUT;
            end
         end
         ST_BUILD_RD:   state_in = ST_SIFT_START;
         ST_SIFT_START: state_in = ST_SIFT;
         ST_SIFT: begin
            if (sift_done) begin
               if (build_ff) begin
                  state_in = (bnode_ff == '0) ? ST_SWAP_RD : ST_BUILD_RD;
               end else begin
                  state_in = (ks_m1 > CNT_W'(1)) ? ST_SWAP_RD : ST_OUT;
               end
            end
         end
         ST_SWAP_RD:    state_in = ST_SWAP_WR;
         ST_SWAP_WR:    state_in = ST_SIFT;
         ST_OUT: begin
            if (out_last) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      min_heap_in  = min_heap_ff;
      ovf_run_in   = ovf_run_ff;
      n_in         = n_ff;
      len_in       = len_ff;
      ks_in        = ks_ff;
      node_in      = node_ff;
      bnode_in     = bnode_ff;
      idx_in       = idx_ff;
      build_in     = build_ff;
      hold_in      = hold_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      wr.en        = 1'b0;
      wr.addr      = node_ff;
      wr.data      = hold_ff;
      rd.addr_a    = node_ff;
      rd.addr_b    = node_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (!full) begin
                  wr.en    = 1'b1;
                  wr.addr  = count_ff[ADDR_W-1:0];
                  wr.data  = req_item_value;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in   = 1'b1;
               end
               if (req_item_last) begin
                  n_in        = n_new;
                  len_in      = n_new;
                  ks_in       = n_new;
                  bnode_in    = half_m1[ADDR_W-1:0];
                  idx_in      = '0;
                  build_in    = 1'b1;
                  min_heap_in = mode_ff;
                  ovf_run_in  = ovf_ff || full;
                  count_in    = '0;
                  ovf_in      = 1'b0;
               end
            end
         end
         ST_BUILD_RD: begin
            rd.addr_a = bnode_ff;
            node_in   = bnode_ff;
         end
         ST_SIFT_START: begin
            hold_in   = rd_a_data;
            rd.addr_a = node_l_addr;
            rd.addr_b = node_l_addr + ADDR_W'(1);
         end
         ST_SIFT: begin
            wr.en = 1'b1;
            if (sift_done) begin
               wr.data = hold_ff;
               if (build_ff) begin
                  if (bnode_ff == '0) begin
                     build_in = 1'b0;
                  end else begin
                     bnode_in = bnode_ff - ADDR_W'(1);
                  end
               end else begin
                  ks_in = ks_m1;
               end
            end else begin
               wr.data   = best_val;
               node_in   = best_node;
               rd.addr_a = best_l_addr;
               rd.addr_b = best_l_addr + ADDR_W'(1);
            end
         end
         ST_SWAP_RD: begin
            rd.addr_a = '0;
            rd.addr_b = ks_m1[ADDR_W-1:0];
         end
         ST_SWAP_WR: begin
            wr.en     = 1'b1;
            wr.addr   = ks_m1[ADDR_W-1:0];
            wr.data   = rd_a_data;
            hold_in   = rd_b_data;
            node_in   = '0;
            len_in    = ks_m1;
            rd.addr_a = ADDR_W'(1);
            rd.addr_b = ADDR_W'(2);
         end
         ST_OUT: begin
            rd.addr_a    = idx_ff;
            idx_in       = idx_ff + ADDR_W'(1);
            rsp_valid_in = 1'b1;
            rsp_last_in  = out_last;
         end
         default: begin
            wr.en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_sort_descending;
         end
      end
   end

   always_ff @(posedge clock) begin
      min_heap_ff <= min_heap_in;
      ovf_run_ff  <= ovf_run_in;
      n_ff        <= n_in;
      len_ff      <= len_in;
      ks_ff       <= ks_in;
      node_ff     <= node_in;
      bnode_ff    <= bnode_in;
      idx_ff      <= idx_in;
      build_ff    <= build_in;
      hold_ff     <= hold_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rd_a_data;
   assign rsp_result_last  = rsp_last_ff;
   assign rsp_overflowed   = ovf_run_ff;

`ifndef SYNTHESIS
   a_strobe_from_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_OUT))
      else $error("result strobe without a streaming cycle");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_last) |=> !rsp_valid)
      else $error("result after the final transaction of a run");

   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      (accept && req_item_last) |=> busy)
      else $error("closing transaction did not start the sort");

   a_sift_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIFT) |-> ({1'b0, node_ff} < len_ff))
      else $error("sift node outside the live heap");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("element count beyond capacity");
`endif

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for heap_sort_engine_unit: sets of signed values in, sorted runs out.
`timescale 1ns / 1ps

module tb import hse_pkg::*;;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam int STALL_LIMIT    = 20000;
   localparam int RANDOM_ITEMS   = 114;
   localparam int CALM_FROM      = 90;
   localparam int DRAIN_CYCLES   = 4;
   localparam int SETTLE_CYCLES  = 50;

   class sort_scoreboard;
      typedef struct packed {
         logic signed [DATA_W-1:0] value;
         logic                     last;
         logic                     dropped;
      } sorted_entry_type;

      logic signed [DATA_W-1:0] set_values[$];
      bit                       set_dropped;
      bit                       descending;
      sorted_entry_type         due_sorted[$];
      int                       errors;

      function void set_order(bit desc);
         descending = desc;
      endfunction

      function void take_value(logic signed [DATA_W-1:0] value, logic last);
         logic signed [DATA_W-1:0] run[$];
         logic signed [DATA_W-1:0] tmp;
         sorted_entry_type         entry;
         int                       j;
         if (set_values.size() < MAX_ITEMS) set_values.push_back(value);
         else set_dropped = 1'b1;
         if (!last) return;
         run = set_values;
         for (int i = 1; i < run.size(); i++) begin
            tmp = run[i];
            j = i;
            while (j > 0 && (descending ? (tmp > run[j-1]) : (tmp < run[j-1]))) begin
               run[j] = run[j-1];
               j--;
            end
            run[j] = tmp;
         end
         for (int k = 0; k < run.size(); k++) begin
            entry.value   = run[k];
            entry.last    = (k == run.size() - 1);
            entry.dropped = set_dropped;
            due_sorted.push_back(entry);
         end
         set_values.delete();
         set_dropped = 1'b0;
      endfunction

      function void check_output(logic signed [DATA_W-1:0] value, logic last, logic dropped);
         sorted_entry_type entry;
         if (due_sorted.size() == 0) begin
            $display("%0t ERROR unexpected transaction: expected none, got value %0d last %0b",
                     $time, value, last);
            errors++;
            return;
         end
         entry = due_sorted.pop_front();
         if (value !== entry.value) begin
            $display("%0t ERROR sorted_value: expected %0d, got %0d", $time, entry.value, value);
            errors++;
         end
         if (last !== entry.last) begin
            $display("%0t ERROR result_last: expected %0b, got %0b", $time, entry.last, last);
            errors++;
         end
         if (dropped !== entry.dropped) begin
            $display("%0t ERROR overflowed: expected %0b, got %0b", $time, entry.dropped, dropped);
            errors++;
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset               = 1'b1;
   logic                     start               = 1'b0;
   logic                     busy;
   logic signed [DATA_W-1:0] req_item_value      = '0;
   logic                     req_item_last       = 1'b0;
   logic                     rsp_valid;
   logic signed [DATA_W-1:0] rsp_sorted_value;
   logic                     rsp_result_last;
   logic                     rsp_overflowed;
   logic                     csr_valid           = 1'b0;
   logic                     csr_ready;
   logic                     csr_sort_descending = 1'b0;
   int                       idle_cycles         = 0;

   sort_scoreboard sb = new();

   heap_sort_engine_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_item_value      (req_item_value),
      .req_item_last       (req_item_last),
      .rsp_valid           (rsp_valid),
      .rsp_sorted_value    (rsp_sorted_value),
      .rsp_result_last     (rsp_result_last),
      .rsp_overflowed      (rsp_overflowed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_sort_descending (csr_sort_descending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         sb.check_output(rsp_sorted_value, rsp_result_last, rsp_overflowed);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return VALUE_MIN;
         1:       return VALUE_MAX;
         2, 3:    return int'($urandom_range(0, 15)) - 8;
         default: return $signed($urandom);
      endcase
   endfunction

   task automatic send_value(input logic signed [DATA_W-1:0] value, input logic last,
                             input bit gaps);
      if (gaps && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      start          <= 1'b1;
      req_item_value <= value;
      req_item_last  <= last;
      do @(posedge clock); while (busy);
      sb.take_value(value, last);
   endtask

   task automatic send_set(input int count, input bit gaps);
      for (int i = 0; i < count; i++)
         send_value(pick_value(), i == count - 1, gaps);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (sb.due_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input bit desc);
      wait_drained();
      csr_valid           <= 1'b1;
      csr_sort_descending <= desc;
      do @(posedge clock); while (!csr_ready);
      sb.set_order(desc);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic signed [DATA_W-1:0] edge_values[7];
      int                       sent;
      int                       count;
      bit                       big_done;
      edge_values = '{VALUE_MIN, VALUE_MAX, 0, -1, 1, -1, VALUE_MAX};
      sent        = 0;
      big_done    = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_order(1'b0);
      send_value(VALUE_MAX, 1'b1, 1'b0);
      for (int i = 0; i < 7; i++) send_value(edge_values[i], i == 6, 1'b0);
      write_order(1'b1);
      for (int i = 0; i < 7; i++) send_value(edge_values[i], i == 6, 1'b0);
      send_value(VALUE_MIN, 1'b1, 1'b0);

      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) write_order($urandom_range(0, 1));
         if (!big_done && sent >= 20) begin
            count    = $urandom_range(MAX_ITEMS, MAX_ITEMS + 3);
            big_done = 1'b1;
         end else begin
            count = $urandom_range(1, 8);
         end
         send_set(count, sent < CALM_FROM);
         sent += count;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.due_sorted.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- files.f -----
sv/hse_pkg.sv
sv/hse_ram.sv
sv/heap_sort_engine_unit.sv
tb/tb.sv
